FILE: rtl/stq_pkg.sv
// Package for the sorted timer queue: transaction structs, entry layout,
// command, status and sequencer state encodings. No dependencies.
`timescale 1ns / 1ps

package stq_pkg;

  localparam int TIME_BITS = 48;
  localparam int ID_BITS   = 16;
  localparam int HDL_BITS  = 16;
  localparam int CNT_BITS  = 5;

  typedef enum logic [2:0] {
    CMD_SCHEDULE = 3'd0,
    CMD_CANCEL   = 3'd1,
    CMD_EXPIRE   = 3'd2,
    CMD_FIRST    = 3'd3,
    CMD_RESET    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]           command;
    logic [TIME_BITS-1:0] now_time;
    logic [TIME_BITS-1:0] delay;
    logic [TIME_BITS-1:0] repeat_interval;
    logic [ID_BITS-1:0]   target_id;
    logic [HDL_BITS-1:0]  task_handle;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 is_expiry;
    logic [ID_BITS-1:0]   result_id;
    logic [HDL_BITS-1:0]  result_handle;
    logic [TIME_BITS-1:0] time_value;
    logic [CNT_BITS-1:0]  expired_count;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] expiry;
    logic [TIME_BITS-1:0] interval;
    logic [ID_BITS-1:0]   id;
    logic [HDL_BITS-1:0]  handle;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCHED_ADD,
    ST_INS_RD,
    ST_INS_CMP,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_REM_RD,
    ST_REM_WR,
    ST_FIRST_WAIT,
    ST_EXP_RD,
    ST_EXP_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_RE_NEXT,
    ST_RE_ADD,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/sorted_timer_queue.sv
// Sorted timer queue: up to QUEUE_DEPTH timers kept in expiry order.
// Depends on stq_pkg and stq_mem.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_ready/in_data) takes one command per
// transaction; the output channel (out_valid/out_ready/out_data) returns its
// results. Every command gives one result with last set, except expire,
// which gives one result per expired timer and then a final result with the
// count and last set.
// The block works on one command at a time; in_ready is high only while the
// sequencer is idle. Timers sit in an entry memory with one read and one
// write port, and each entry visited is read, then compared or moved.
// Schedule walks the list from the tail (no walk when the queue is
// full), cancel and reset search from the head, and cancel then closes the
// gap; first reads the head entry and an unknown command needs no access.
// Expire reports each expired timer, closes the gap they leave, and gives
// each repeating timer a new expiry and an insertion walk.
// Reset (rst_n low, synchronous) empties the queue and zeroes the id counter
// at once; no clearing pass is needed. A finished result waits in the output
// register, and a stalled receiver only holds the sequencer when it has a
// further result to deliver.
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(entry_t);

  state_t             state_r, state_nxt, ret_r, ret_nxt;
  in_t                in_r, in_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [ID_BITS-1:0] idc_r, idc_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      nexp_r, nexp_nxt;
  logic [CW-1:0]      nre_r, nre_nxt;
  logic [CW-1:0]      rei_r, rei_nxt;
  logic               reins_r, reins_nxt;
  entry_t             new_r, new_nxt;
  out_t               res_r, res_nxt;
  out_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               e_we, s_we;
  logic [AW-1:0]      e_wa, e_ra, s_wa, s_ra;
  entry_t             e_wd, s_wd;
  logic [EW-1:0]      e_rd_raw, s_rd_raw;
  entry_t             e_rd, s_rd;

  // Shared arithmetic: one saturating adder and one less-or-equal compare.
  logic [TIME_BITS-1:0] add_b, add_res, cmp_key;
  logic [TIME_BITS:0]   add_sum;
  logic                 cmp_le;
  logic [ID_BITS-1:0]   idc_inc;
  logic [CW:0]          sh_src;
  logic [CW+CNT_BITS-1:0] nexp_wide;

  stq_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_entries (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd),
    .raddr(e_ra), .rdata(e_rd_raw)
  );

  stq_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_stash (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd),
    .raddr(s_ra), .rdata(s_rd_raw)
  );

  assign e_rd = entry_t'(e_rd_raw);
  assign s_rd = entry_t'(s_rd_raw);

  assign add_b   = (state_r == ST_SCHED_ADD) ? in_r.delay : s_rd.interval;
  assign add_sum = {1'b0, in_r.now_time} + {1'b0, add_b};
  assign add_res = add_sum[TIME_BITS] ? '1 : add_sum[TIME_BITS-1:0];

  assign cmp_key = (state_r == ST_INS_CMP) ? new_r.expiry : in_r.now_time;
  assign cmp_le  = (e_rd.expiry <= cmp_key);

  assign idc_inc   = idc_r + 1'b1;
  assign sh_src    = {1'b0, idx_r} + {1'b0, nexp_r};
  assign nexp_wide = (CW + CNT_BITS)'(nexp_r);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      cnt_r       <= '0;
      idc_r       <= '0;
      out_valid_r <= 1'b0;
      reins_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      idc_r       <= idc_nxt;
      out_valid_r <= out_valid_nxt;
      reins_r     <= reins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    idx_r  <= idx_nxt;
    nexp_r <= nexp_nxt;
    nre_r  <= nre_nxt;
    rei_r  <= rei_nxt;
    new_r  <= new_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    in_nxt        = in_r;
    cnt_nxt       = cnt_r;
    idc_nxt       = idc_r;
    idx_nxt       = idx_r;
    nexp_nxt      = nexp_r;
    nre_nxt       = nre_r;
    rei_nxt       = rei_r;
    reins_nxt     = reins_r;
    new_nxt       = new_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    e_we = 1'b0;
    e_wa = idx_r[AW-1:0];
    e_wd = new_r;
    e_ra = idx_r[AW-1:0];
    s_we = 1'b0;
    s_wa = nre_r[AW-1:0];
    s_wd = e_rd;
    s_ra = rei_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt  = in_data;
          res_nxt = '0;
          res_nxt.last = 1'b1;
          ret_nxt = ST_IDLE;
          idx_nxt = '0;
          case (in_data.command)
            CMD_SCHEDULE: begin
              if (cnt_r == CW'(QUEUE_DEPTH)) begin
                res_nxt.status = STAT_FULL;
                state_nxt = ST_EMIT;
              end else begin
                idc_nxt   = (idc_inc == '0) ? ID_BITS'(1) : idc_inc;
                state_nxt = ST_SCHED_ADD;
              end
            end
            CMD_CANCEL, CMD_RESET: state_nxt = ST_FIND_RD;
            CMD_EXPIRE: begin
              nre_nxt   = '0;
              state_nxt = ST_EXP_RD;
            end
            CMD_FIRST: begin
              if (cnt_r == '0) begin
                res_nxt.status = STAT_EMPTY;
                state_nxt = ST_EMIT;
              end else begin
                e_ra      = '0;
                state_nxt = ST_FIRST_WAIT;
              end
            end
            default: state_nxt = ST_EMIT;
          endcase
        end
      end

      ST_SCHED_ADD: begin
        new_nxt.expiry   = add_res;
        new_nxt.interval = in_r.repeat_interval;
        new_nxt.id       = idc_r;
        new_nxt.handle   = in_r.task_handle;
        idx_nxt          = cnt_r;
        reins_nxt        = 1'b0;
        state_nxt        = ST_INS_RD;
      end

      // Walk down from the tail, moving later entries up by one slot.
      ST_INS_RD: begin
        if (idx_r == '0) begin
          e_we    = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (reins_r) begin
            state_nxt = ST_RE_NEXT;
          end else begin
            res_nxt.result_id = new_r.id;
            state_nxt = ST_EMIT;
          end
        end else begin
          e_ra      = AW'(idx_r - 1'b1);
          state_nxt = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        e_we = 1'b1;
        if (cmp_le) begin
          cnt_nxt = cnt_r + 1'b1;
          if (reins_r) begin
            state_nxt = ST_RE_NEXT;
          end else begin
            res_nxt.result_id = new_r.id;
            state_nxt = ST_EMIT;
          end
        end else begin
          e_wd      = e_rd;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = ST_INS_RD;
        end
      end

      ST_FIND_RD: begin
        if (idx_r == cnt_r) begin
          if (in_r.command == CMD_RESET) begin
            res_nxt.status = STAT_NOT_FOUND;
          end
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_FIND_CMP;
        end
      end

      ST_FIND_CMP: begin
        if (e_rd.id == in_r.target_id) begin
          if (in_r.command == CMD_RESET) begin
            e_we          = 1'b1;
            e_wd          = e_rd;
            e_wd.interval = in_r.repeat_interval;
            state_nxt     = ST_EMIT;
          end else begin
            state_nxt = ST_REM_RD;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_FIND_RD;
        end
      end

      // Close the gap left by a cancelled entry.
      ST_REM_RD: begin
        if ({1'b0, idx_r} + 1'b1 >= {1'b0, cnt_r}) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          e_ra      = AW'(idx_r + 1'b1);
          state_nxt = ST_REM_WR;
        end
      end

      ST_REM_WR: begin
        e_we      = 1'b1;
        e_wd      = e_rd;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_REM_RD;
      end

      ST_FIRST_WAIT: begin
        res_nxt.time_value = e_rd.expiry;
        state_nxt = ST_EMIT;
      end

      // Expired timers form a prefix of the list; report them in order
      // and keep the repeating ones aside for reinsertion.
      ST_EXP_RD: begin
        if (idx_r == cnt_r) begin
          nexp_nxt  = idx_r;
          idx_nxt   = '0;
          state_nxt = ST_SH_RD;
        end else begin
          state_nxt = ST_EXP_CMP;
        end
      end

      ST_EXP_CMP: begin
        if (cmp_le) begin
          res_nxt               = '0;
          res_nxt.is_expiry     = 1'b1;
          res_nxt.result_id     = e_rd.id;
          res_nxt.result_handle = e_rd.handle;
          if (e_rd.interval != '0) begin
            s_we    = 1'b1;
            nre_nxt = nre_r + 1'b1;
          end
          idx_nxt   = idx_r + 1'b1;
          ret_nxt   = ST_EXP_RD;
          state_nxt = ST_EMIT;
        end else begin
          nexp_nxt  = idx_r;
          idx_nxt   = '0;
          state_nxt = ST_SH_RD;
        end
      end

      ST_SH_RD: begin
        if (sh_src >= {1'b0, cnt_r}) begin
          cnt_nxt   = cnt_r - nexp_r;
          rei_nxt   = '0;
          state_nxt = ST_RE_NEXT;
        end else begin
          e_ra      = sh_src[AW-1:0];
          state_nxt = ST_SH_WR;
        end
      end

      ST_SH_WR: begin
        e_we      = 1'b1;
        e_wd      = e_rd;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_SH_RD;
      end

      ST_RE_NEXT: begin
        if (rei_r == nre_r) begin
          res_nxt               = '0;
          res_nxt.expired_count = nexp_wide[CNT_BITS-1:0];
          res_nxt.last          = 1'b1;
          ret_nxt               = ST_IDLE;
          state_nxt             = ST_EMIT;
        end else begin
          state_nxt = ST_RE_ADD;
        end
      end

      ST_RE_ADD: begin
        new_nxt        = s_rd;
        new_nxt.expiry = add_res;
        idx_nxt        = cnt_r;
        reins_nxt      = 1'b1;
        rei_nxt        = rei_r + 1'b1;
        state_nxt      = ST_INS_RD;
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ret_r;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/stq_mem.sv
// Single-port-write, single-port-read memory with registered read data.
// Holds timer entries for the sorted timer queue; no package dependency.
`timescale 1ns / 1ps

module stq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/stq_checker.sv
// Port-level checks for the sorted timer queue, bound to the top level.
// Depends on stq_pkg.
`timescale 1ns / 1ps

module stq_checker
  import stq_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // in_ready is low in the cycle after every accepted command.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted command");

  // Only expiry reports may leave a command's results open.
  a_last_or_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last != out_data.is_expiry))
    else $error("result is neither final nor an expiry report");

  a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_expiry |-> out_data.status == STAT_OK)
    else $error("expiry report with nonzero status");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

FILE: tb/sv/sorted_timer_queue_tb.sv
// Self-checking testbench for the sorted timer queue: directed and random
// command streams checked against a behavioral timer list. Depends on stq_pkg.
`timescale 1ns / 1ps

module sorted_timer_queue_tb;
  import stq_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [TIME_BITS-1:0] expiry;
    logic [TIME_BITS-1:0] interval;
    logic [ID_BITS-1:0]   id;
    logic [HDL_BITS-1:0]  handle;
  } timer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  sorted_timer_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Behavioral timer list.
  timer_t timers[$];
  logic [ID_BITS-1:0] id_seq;
  in_t  pending_cmds[$];
  out_t expected_results[$];
  int errors = 0;
  int issued_ids[$];
  bit quiet = 0;
  bit hold_receiver = 0;
  bit in_taken = 0;
  int accepted_cmds = 0;
  int accepted_results = 0;
  int expiry_results = 0;
  int full_hits = 0;

  function automatic logic [TIME_BITS-1:0] sat_sum(logic [TIME_BITS-1:0] a,
                                                   logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
  endfunction

  function automatic void insert_timer(timer_t t);
    int p;
    p = 0;
    while (p < timers.size() && timers[p].expiry <= t.expiry) p++;
    timers.insert(p, t);
  endfunction

  function automatic int find_timer(logic [ID_BITS-1:0] id);
    foreach (timers[i]) if (timers[i].id == id) return i;
    return -1;
  endfunction

  function automatic void enqueue_cmd(in_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic void push_result(logic [1:0] st, logic ex, logic [ID_BITS-1:0] id,
                                      logic [HDL_BITS-1:0] h, logic [TIME_BITS-1:0] tv,
                                      logic [CNT_BITS-1:0] cnt, logic lst);
    out_t r;
    r.status = st; r.is_expiry = ex; r.result_id = id; r.result_handle = h;
    r.time_value = tv; r.expired_count = cnt; r.last = lst;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void predict_timer_cmd(in_t c);
    int pos;
    int k;
    timer_t t;
    timer_t rearm[$];
    case (c.command)
      CMD_SCHEDULE: begin
        if (timers.size() >= DEPTH) begin
          push_result(STAT_FULL, 0, 0, 0, 0, 0, 1);
          full_hits++;
        end else begin
          id_seq = id_seq + 1'b1;
          if (id_seq == 0) id_seq = 1;
          t.expiry = sat_sum(c.now_time, c.delay);
          t.interval = c.repeat_interval;
          t.id = id_seq;
          t.handle = c.task_handle;
          insert_timer(t);
          issued_ids.insert(issued_ids.size(), int'(id_seq));
          push_result(STAT_OK, 0, id_seq, 0, 0, 0, 1);
        end
      end
      CMD_CANCEL: begin
        pos = find_timer(c.target_id);
        if (pos >= 0) timers.delete(pos);
        push_result(STAT_OK, 0, 0, 0, 0, 0, 1);
      end
      CMD_EXPIRE: begin
        k = 0;
        while (timers.size() > 0 && timers[0].expiry <= c.now_time) begin
          t = timers.pop_front();
          push_result(STAT_OK, 1, t.id, t.handle, 0, 0, 0);
          k++;
          if (t.interval != 0) begin
            t.expiry = sat_sum(c.now_time, t.interval);
            rearm.insert(rearm.size(), t);
          end
        end
        foreach (rearm[i]) insert_timer(rearm[i]);
        push_result(STAT_OK, 0, 0, 0, 0, CNT_BITS'(k), 1);
      end
      CMD_FIRST: begin
        if (timers.size() == 0) push_result(STAT_EMPTY, 0, 0, 0, 0, 0, 1);
        else push_result(STAT_OK, 0, 0, 0, timers[0].expiry, 0, 1);
      end
      CMD_RESET: begin
        pos = find_timer(c.target_id);
        if (pos < 0) begin
          push_result(STAT_NOT_FOUND, 0, 0, 0, 0, 0, 1);
        end else begin
          timers[pos].interval = c.repeat_interval;
          push_result(STAT_OK, 0, 0, 0, 0, 0, 1);
        end
      end
      default: push_result(STAT_OK, 0, 0, 0, 0, 0, 1);
    endcase
  endfunction

  // Driver: presents queued commands, with random idle bursts.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        // Transaction taken at the last rising edge.
        in_taken = 1'b0;
        if (!quiet && send_gap == 0 && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 4);
        if (send_gap == 0 && pending_cmds.size() > 0) begin
          in_data <= pending_cmds.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_cmds.size() > 0) begin
          in_data <= pending_cmds.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Prediction happens on the accepting edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_timer_cmd(in_data);
      accepted_cmds++;
      in_taken = 1'b1;
    end
  end

  // Receiver: ready with random stall bursts, or held off for a long stretch.
  int recv_gap = 0;
  always @(negedge clk) begin
    if (!rst_n || hold_receiver) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: compare each result with the oldest expectation.
  out_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      accepted_results++;
      if (expected_results.size() == 0) begin
        $error("unexpected result %p", out_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.is_expiry) expiry_results++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_data.status); errors++;
        end
        if (out_data.is_expiry !== want.is_expiry) begin
          $error("is_expiry: expected %0d actual %0d", want.is_expiry, out_data.is_expiry);
          errors++;
        end
        if (out_data.result_id !== want.result_id) begin
          $error("result_id: expected %0d actual %0d", want.result_id, out_data.result_id);
          errors++;
        end
        if (out_data.result_handle !== want.result_handle) begin
          $error("result_handle: expected %0d actual %0d", want.result_handle,
                 out_data.result_handle);
          errors++;
        end
        if (out_data.time_value !== want.time_value) begin
          $error("time_value: expected %0d actual %0d", want.time_value, out_data.time_value);
          errors++;
        end
        if (out_data.expired_count !== want.expired_count) begin
          $error("expired_count: expected %0d actual %0d", want.expired_count,
                 out_data.expired_count);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d actual %0d", want.last, out_data.last); errors++;
        end
      end
    end
  end

  // Watchdog over cycles with no transaction on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_t make_cmd(cmd_t op, logic [TIME_BITS-1:0] now_t,
                                   logic [TIME_BITS-1:0] dly, logic [TIME_BITS-1:0] ivl,
                                   logic [ID_BITS-1:0] tid, logic [HDL_BITS-1:0] h);
    in_t c;
    c.command = op; c.now_time = now_t; c.delay = dly;
    c.repeat_interval = ivl; c.target_id = tid; c.task_handle = h;
    return c;
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  function automatic logic [ID_BITS-1:0] pick_id();
    if (issued_ids.size() > 0 && $urandom_range(0, 3) != 0)
      return ID_BITS'(issued_ids[$urandom_range(0, issued_ids.size() - 1)]);
    return ID_BITS'($urandom);
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Random command with a small, mostly advancing wall clock.
  logic [TIME_BITS-1:0] wall;
  function automatic in_t rand_cmd();
    int sel;
    logic [TIME_BITS-1:0] dly;
    logic [TIME_BITS-1:0] ivl;
    sel = $urandom_range(0, 99);
    wall = wall + TIME_BITS'($urandom_range(0, 40));
    dly = ($urandom_range(0, 9) == 0) ? rand_time() : TIME_BITS'($urandom_range(0, 120));
    ivl = ($urandom_range(0, 2) == 0) ? '0 :
          ($urandom_range(0, 9) == 0) ? rand_time() : TIME_BITS'($urandom_range(1, 100));
    if (sel < 35)
      return make_cmd(CMD_SCHEDULE, wall, dly, ivl, ID_BITS'($urandom), HDL_BITS'($urandom));
    if (sel < 50)
      return make_cmd(CMD_CANCEL, wall, dly, ivl, pick_id(), HDL_BITS'($urandom));
    if (sel < 75)
      return make_cmd(CMD_EXPIRE, wall, dly, ivl, ID_BITS'($urandom), HDL_BITS'($urandom));
    if (sel < 85)
      return make_cmd(CMD_FIRST, wall, dly, ivl, ID_BITS'($urandom), HDL_BITS'($urandom));
    if (sel < 97)
      return make_cmd(CMD_RESET, wall, dly, ivl, pick_id(), HDL_BITS'($urandom));
    return make_cmd(cmd_t'(3'($urandom_range(5, 7))), rand_time(), rand_time(), rand_time(),
                    ID_BITS'($urandom), HDL_BITS'($urandom));
  endfunction

  initial begin
    timers = {};
    id_seq = '0;
    wall = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: empty-queue cases, extremes, saturation, equal expiries.
    enqueue_cmd(make_cmd(CMD_FIRST, 0, 0, 0, 0, 0));
    enqueue_cmd(make_cmd(CMD_EXPIRE, TMAX, 0, 0, 0, 0));
    enqueue_cmd(make_cmd(CMD_CANCEL, 0, 0, 0, 16'hFFFF, 0));
    enqueue_cmd(make_cmd(CMD_RESET, 0, 0, 5, 16'h1234, 0));
    enqueue_cmd(make_cmd(CMD_SCHEDULE, TMAX, TMAX, TMAX, 16'hFFFF, 16'hFFFF));
    enqueue_cmd(make_cmd(CMD_SCHEDULE, 10, 5, 0, 0, 16'h0001));
    enqueue_cmd(make_cmd(CMD_SCHEDULE, 12, 3, 7, 0, 16'h0002));
    enqueue_cmd(make_cmd(CMD_SCHEDULE, 0, 15, 0, 0, 16'h0003));
    enqueue_cmd(make_cmd(CMD_FIRST, 0, 0, 0, 0, 0));
    enqueue_cmd(make_cmd(CMD_RESET, 0, 0, 20, 16'd3, 0));
    enqueue_cmd(make_cmd(CMD_CANCEL, 0, 0, 0, 16'd4, 0));
    enqueue_cmd(make_cmd(CMD_EXPIRE, 14, 0, 0, 0, 0));
    enqueue_cmd(make_cmd(CMD_EXPIRE, 15, 0, 0, 0, 0));
    enqueue_cmd(make_cmd(CMD_EXPIRE, TMAX - 1, 0, 0, 0, 0));
    enqueue_cmd(make_cmd(cmd_t'(3'd7), TMAX, TMAX, TMAX, 16'hFFFF, 16'hFFFF));
    enqueue_cmd(make_cmd(cmd_t'(3'd5), 0, 0, 0, 0, 0));
    enqueue_cmd(make_cmd(CMD_EXPIRE, TMAX, 0, 0, 0, 0));
    wait_drained();

    // Fill past capacity with the receiver held off, then expire all 16.
    hold_receiver = 1;
    for (int i = 0; i < 18; i++)
      enqueue_cmd(make_cmd(CMD_SCHEDULE, 100, TIME_BITS'(i % 4),
                           (i % 2) ? TIME_BITS'(50) : '0, 0, HDL_BITS'(i)));
    repeat (300) @(posedge clk);
    hold_receiver = 0;
    enqueue_cmd(make_cmd(CMD_EXPIRE, 200, 0, 0, 0, 0));
    enqueue_cmd(make_cmd(CMD_EXPIRE, TMAX, 0, 0, 0, 0));
    wait_drained();
    wall = 300;

    for (int i = 0; i < 340; i++) enqueue_cmd(rand_cmd());
    wait_drained();

    // Id counter wrap: cycle schedule and cancel past 2^16 ids would be slow,
    // so run the tail with no idling instead.
    quiet = 1;
    for (int i = 0; i < 40; i++) enqueue_cmd(rand_cmd());
    enqueue_cmd(make_cmd(CMD_EXPIRE, TMAX, 0, 0, 0, 0));
    wait_drained();

    $display("Covered %0d commands, %0d results, %0d expiry reports, %0d full rejections.",
             accepted_cmds, accepted_results, expiry_results, full_hits);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
